[rtl/afd_pkg.sv]
package afd_pkg;

    // Default build of the block
    localparam int WINDOW_SIZE_DEF = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths of the arithmetic
    localparam int SUM_W      = 20;
    localparam int FRAC_W     = 4;
    localparam int MAG_W      = SUM_W + FRAC_W;
    localparam int AVG_W      = 20;
    localparam int LIMIT_W    = 16;
    localparam int FALL_W     = 3;
    localparam int RECIP_SHIFT = 31;

    // Pipeline depth from input transfer to output register
    localparam int STAGES = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIBRATED  = 3'd0,
        REG_FRONT_LIMIT = 3'd1,
        REG_BACK_LIMIT  = 3'd2,
        REG_RIGHT_LIMIT = 3'd3,
        REG_LEFT_LIMIT  = 3'd4
    } cfg_index_t;

    localparam logic signed [LIMIT_W-1:0] LIMIT_MIN = {1'b1, {(LIMIT_W-1){1'b0}}};
    localparam logic signed [LIMIT_W-1:0] LIMIT_MAX = {1'b0, {(LIMIT_W-1){1'b1}}};

    // Output stream packing
    localparam int OUT_FIELD_W = 2 * AVG_W + FALL_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [FALL_W-1:0] {
        FALL_STANDING = 3'd0,
        FALL_FORWARD  = 3'd1,
        FALL_BACKWARD = 3'd2,
        FALL_RIGHT    = 3'd3,
        FALL_LEFT     = 3'd4
    } fall_code_t;

    // Window control and per-stage advance enables, shared by both lanes
    typedef struct packed {
        logic               accumulate;
        logic               close;
        logic [STAGES-1:0]  adv;
    } afd_ctrl_t;

    // Limit comparison results of one lane
    typedef struct packed {
        logic below;
        logic above;
    } afd_flags_t;

endpackage

[rtl/accel_block_average_fall_detect.sv]
// Pipeline: there are five register stages, and the first loads at the transfer edge;
// m_tvalid rises when the result reaches the last stage.
// Throughput: one sample per cycle while m_tready stays high; the five-stage average pipeline
// (reciprocal multiply, remainder correction, saturation) advances on each cycle that it is not stalled.
// Each stage moves on when it is empty or the next stage moves, so bubbles close up.
// Reset (aresetn low, synchronous): window counter and all sums cleared,
// calibrated 0, limits at their extreme values, pipeline emptied.
module accel_block_average_fall_detect #(
    parameter int WINDOW_SIZE = afd_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = afd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // lowest bit up: roll_sample, pitch_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // lowest bit up: roll_average, pitch_average, fall_code
    output logic [afd_pkg::OUT_DATA_W-1:0]         m_tdata,
    // window_closed
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_wr_en,
    input  logic [afd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int STAGES = afd_pkg::STAGES;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int LIMIT_W = afd_pkg::LIMIT_W;
    localparam int AVG_W  = afd_pkg::AVG_W;
    localparam int PAD_W  = afd_pkg::OUT_DATA_W - afd_pkg::OUT_FIELD_W;
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW_SIZE);

    // Configuration registers
    logic                      calibrated_reg;
    logic signed [LIMIT_W-1:0] front_limit_reg, back_limit_reg;
    logic signed [LIMIT_W-1:0] right_limit_reg, left_limit_reg;

    // Control
    logic                      ready_ok_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [STAGES-1:0]         valid_reg;
    logic [STAGES-2:0]         closed_pipe_reg;
    logic [STAGES-1:0]         adv;
    logic                      in_xfer;
    afd_pkg::afd_ctrl_t        ctrl;

    // Lane results
    afd_pkg::afd_flags_t       roll_flags, pitch_flags;
    logic [AVG_W-1:0]          roll_average, pitch_average;
    logic [afd_pkg::FALL_W-1:0] fall_code;
    logic                      window_closed;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibrated_reg  <= 1'b0;
            front_limit_reg <= afd_pkg::LIMIT_MIN;
            back_limit_reg  <= afd_pkg::LIMIT_MAX;
            right_limit_reg <= afd_pkg::LIMIT_MAX;
            left_limit_reg  <= afd_pkg::LIMIT_MIN;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                afd_pkg::REG_CALIBRATED:  calibrated_reg  <= cfg_wdata[0];
                afd_pkg::REG_FRONT_LIMIT: front_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                afd_pkg::REG_BACK_LIMIT:  back_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                afd_pkg::REG_RIGHT_LIMIT: right_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                afd_pkg::REG_LEFT_LIMIT:  left_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0] && ready_ok_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // Window control
    assign ctrl.accumulate = in_xfer && calibrated_reg && (count_reg < WIN_CNT);
    assign ctrl.close      = in_xfer && calibrated_reg && !(count_reg < WIN_CNT);
    assign ctrl.adv        = adv;

    always_comb begin
        count_next = count_reg;
        if (ctrl.close) begin
            count_next = '0;
        end else if (ctrl.accumulate) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_ok_reg <= 1'b0;
            count_reg    <= '0;
            valid_reg    <= '0;
        end else begin
            ready_ok_reg <= 1'b1;
            count_reg    <= count_next;
            if (adv[0]) begin
                valid_reg[0] <= in_xfer;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Carry the close flag alongside the averages
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            closed_pipe_reg[0] <= ctrl.close;
        end
        for (int k = 1; k < STAGES - 1; k++) begin
            if (adv[k]) begin
                closed_pipe_reg[k] <= closed_pipe_reg[k-1];
            end
        end
    end

    afd_lane #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_roll_lane (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .low_limit  (left_limit_reg),
        .high_limit (right_limit_reg),
        .flags      (roll_flags),
        .average    (roll_average)
    );

    afd_lane #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pitch_lane (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .sample     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .low_limit  (front_limit_reg),
        .high_limit (back_limit_reg),
        .flags      (pitch_flags),
        .average    (pitch_average)
    );

    afd_merge u_merge (
        .aclk          (aclk),
        .adv           (adv[STAGES-1]),
        .roll_flags    (roll_flags),
        .pitch_flags   (pitch_flags),
        .closed        (closed_pipe_reg[STAGES-2]),
        .fall_code     (fall_code),
        .window_closed (window_closed)
    );

    assign m_tdata  = {{PAD_W{1'b0}}, fall_code, pitch_average, roll_average};
    assign m_tuser  = window_closed;
    assign m_tvalid = valid_reg[STAGES-1];

    // The counter never runs past the window length
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= WIN_CNT)
        else $error("window counter past window length");

    // A window closes only on the transfer after a full window
    a_close_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.close |-> count_reg == WIN_CNT)
        else $error("window closed early");

    // Closing a window restarts the count
    a_close_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.close |=> count_reg == '0)
        else $error("counter not cleared after close");

    // Uncalibrated samples leave the count alone
    a_uncal_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !calibrated_reg) |=> $stable(count_reg))
        else $error("uncalibrated sample changed the counter");

    // A close flag enters the pipeline only together with a valid result
    a_closed_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.close |=> valid_reg[0] && closed_pipe_reg[0])
        else $error("close flag lost entering pipeline");

endmodule

[rtl/afd_lane.sv]
module afd_lane #(
    parameter int WINDOW_SIZE = afd_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = afd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  afd_pkg::afd_ctrl_t                       ctrl,
    input  logic signed [SAMPLE_BITS-1:0]            sample,
    input  logic signed [afd_pkg::LIMIT_W-1:0]       low_limit,
    input  logic signed [afd_pkg::LIMIT_W-1:0]       high_limit,
    output afd_pkg::afd_flags_t                      flags,
    output logic [afd_pkg::AVG_W-1:0]                average
);

    localparam int SUM_W  = afd_pkg::SUM_W;
    localparam int MAG_W  = afd_pkg::MAG_W;
    localparam int AVG_W  = afd_pkg::AVG_W;
    localparam int FRAC_W = afd_pkg::FRAC_W;
    localparam int WB     = $clog2(WINDOW_SIZE + 1);
    localparam int LIM_W  = afd_pkg::LIMIT_W + WB;
    localparam int CMP_W  = (LIM_W > SUM_W) ? LIM_W : SUM_W;
    localparam int EXT_W  = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
    localparam int PROD_W = MAG_W + 32;
    localparam int BACK_W = MAG_W + WB;
    localparam int REM_W  = $clog2(2 * WINDOW_SIZE);
    localparam int RS     = afd_pkg::RECIP_SHIFT;

    localparam logic [31:0] RECIP = 32'((64'd1 << RS) / WINDOW_SIZE);
    localparam logic signed [LIM_W-1:0] W_LIM = LIM_W'(WINDOW_SIZE);
    localparam logic [MAG_W-1:0] W_MAG = MAG_W'(WINDOW_SIZE);
    localparam logic [BACK_W-1:0] W_BACK = BACK_W'(WINDOW_SIZE);
    localparam logic [REM_W-1:0] W_REM = REM_W'(WINDOW_SIZE);
    localparam logic [MAG_W-1:0] NEG_BOUND = MAG_W'(1) << (AVG_W - 1);
    localparam logic [MAG_W-1:0] POS_BOUND = NEG_BOUND - MAG_W'(1);
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};
    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};

    // Window state
    logic signed [SUM_W-1:0] run_sum_reg, run_sum_next;
    logic signed [SUM_W-1:0] win_sum_reg, win_sum_next;
    logic signed [EXT_W-1:0] sample_ext;

    // Scaled limits
    logic signed [LIM_W-1:0] low_scaled_reg, high_scaled_reg;

    // Pipeline payload
    logic signed [SUM_W-1:0] p1_sum_reg;
    logic signed [MAG_W-1:0] p1_scaled;
    logic signed [CMP_W-1:0] p1_cmp;
    logic [MAG_W-1:0]        p1_mag;
    logic                    p2_neg_reg, p3_neg_reg, p4_neg_reg;
    logic [MAG_W-1:0]        p2_mag_reg, p3_mag_reg;
    afd_pkg::afd_flags_t     p2_flags_reg, p3_flags_reg, p4_flags_reg;
    logic [PROD_W-1:0]       p2_prod;
    logic [MAG_W-1:0]        p3_quot_reg, p4_quot_reg;
    logic [BACK_W-1:0]       p3_back;
    logic [BACK_W-1:0]       p3_rem_full;
    logic [REM_W-1:0]        p3_rem;
    logic [MAG_W-1:0]        p4_neg_quot;
    logic [AVG_W-1:0]        average_reg, average_next;

    // Accumulate into the running sum, latch it on window close
    assign sample_ext = EXT_W'(sample);

    always_comb begin
        run_sum_next = run_sum_reg;
        win_sum_next = win_sum_reg;
        if (ctrl.accumulate) begin
            run_sum_next = run_sum_reg + sample_ext[SUM_W-1:0];
        end else if (ctrl.close) begin
            win_sum_next = run_sum_reg;
            run_sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg <= '0;
            win_sum_reg <= '0;
        end else begin
            run_sum_reg <= run_sum_next;
            win_sum_reg <= win_sum_next;
        end
    end

    // Scale the limits by the window length
    always_ff @(posedge aclk) begin
        low_scaled_reg  <= LIM_W'(low_limit) * W_LIM;
        high_scaled_reg <= LIM_W'(high_limit) * W_LIM;
    end

    // Stage 1: capture the window sum seen by this transfer
    always_ff @(posedge aclk) begin
        if (ctrl.adv[0]) begin
            p1_sum_reg <= win_sum_next;
        end
    end

    // Stage 2: magnitude for floor division, limit compares
    assign p1_scaled = {p1_sum_reg, {FRAC_W{1'b0}}};
    assign p1_cmp    = CMP_W'(p1_sum_reg);
    assign p1_mag    = p1_sum_reg[SUM_W-1] ? (~p1_scaled + W_MAG) : p1_scaled;

    always_ff @(posedge aclk) begin
        if (ctrl.adv[1]) begin
            p2_neg_reg         <= p1_sum_reg[SUM_W-1];
            p2_mag_reg         <= p1_mag;
            p2_flags_reg.below <= p1_cmp < CMP_W'(low_scaled_reg);
            p2_flags_reg.above <= p1_cmp > CMP_W'(high_scaled_reg);
        end
    end

    // Stage 3: reciprocal multiply, quotient low by at most one
    assign p2_prod = PROD_W'(p2_mag_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (ctrl.adv[2]) begin
            p3_quot_reg  <= p2_prod[RS+MAG_W-1:RS];
            p3_mag_reg   <= p2_mag_reg;
            p3_neg_reg   <= p2_neg_reg;
            p3_flags_reg <= p2_flags_reg;
        end
    end

    // Stage 4: correct the quotient from the remainder
    assign p3_back     = BACK_W'(p3_quot_reg) * W_BACK;
    assign p3_rem_full = BACK_W'(p3_mag_reg) - p3_back;
    assign p3_rem      = p3_rem_full[REM_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.adv[3]) begin
            p4_quot_reg  <= (p3_rem >= W_REM) ? (p3_quot_reg + MAG_W'(1)) : p3_quot_reg;
            p4_neg_reg   <= p3_neg_reg;
            p4_flags_reg <= p3_flags_reg;
        end
    end

    // Stage 5: apply the sign and saturate
    assign p4_neg_quot = -p4_quot_reg;

    always_comb begin
        if (p4_neg_reg) begin
            average_next = (p4_quot_reg > NEG_BOUND) ? AVG_MIN : p4_neg_quot[AVG_W-1:0];
        end else begin
            average_next = (p4_quot_reg > POS_BOUND) ? AVG_MAX : p4_quot_reg[AVG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv[4]) begin
            average_reg <= average_next;
        end
    end

    assign average = average_reg;
    assign flags   = p4_flags_reg;

endmodule

[rtl/afd_merge.sv]
module afd_merge (
    input  logic                            aclk,
    input  logic                            adv,
    input  afd_pkg::afd_flags_t             roll_flags,
    input  afd_pkg::afd_flags_t             pitch_flags,
    input  logic                            closed,
    output logic [afd_pkg::FALL_W-1:0]      fall_code,
    output logic                            window_closed
);

    afd_pkg::fall_code_t fall_code_reg, fall_code_next;
    logic                closed_reg;

    // Prioritise forward, backward, right, left
    always_comb begin
        if (pitch_flags.below) begin
            fall_code_next = afd_pkg::FALL_FORWARD;
        end else if (pitch_flags.above) begin
            fall_code_next = afd_pkg::FALL_BACKWARD;
        end else if (roll_flags.above) begin
            fall_code_next = afd_pkg::FALL_RIGHT;
        end else if (roll_flags.below) begin
            fall_code_next = afd_pkg::FALL_LEFT;
        end else begin
            fall_code_next = afd_pkg::FALL_STANDING;
        end
    end

    // Hold the result in the output stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            fall_code_reg <= fall_code_next;
            closed_reg    <= closed;
        end
    end

    assign fall_code     = fall_code_reg;
    assign window_closed = closed_reg;

endmodule
